/* rtl/ibe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibe_pkg
// Shared constants, status codes and control types of the interval booking
// engine.
// ----------------------------------------------------------------------------
package ibe_pkg;

  localparam int TIME_BITS_DEF    = 30;
  localparam int MAX_BOOKINGS_DEF = 64;

  localparam int STATUS_W = 2;
  localparam int OUT_W    = 8;

  localparam logic [STATUS_W-1:0] ST_BOOKED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERLAP = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd3;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dp_sts_t;

endpackage

/* rtl/ibe_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibe_ctrl
// Request sequencer: accept a request, scan the booking table, hand the
// result to the output register.
// ----------------------------------------------------------------------------
module ibe_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  ibe_pkg::dp_sts_t  sts,
  output ibe_pkg::ctl_cmd_t cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/ibe_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibe_datapath
// Request registers, booking table memory, scan counter, overlap compare,
// status decision and output register.
// ----------------------------------------------------------------------------
module ibe_datapath #(
  parameter int TIME_BITS    = ibe_pkg::TIME_BITS_DEF,
  parameter int MAX_BOOKINGS = ibe_pkg::MAX_BOOKINGS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [TIME_BITS-1:0]     in_start,
  input  logic [TIME_BITS-1:0]     in_end,
  input  ibe_pkg::ctl_cmd_t        cmd,
  output ibe_pkg::dp_sts_t         sts,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [ibe_pkg::OUT_W-1:0] m_tdata
);

  localparam int CW = $clog2(MAX_BOOKINGS + 1);
  localparam int AW = (MAX_BOOKINGS > 1) ? $clog2(MAX_BOOKINGS) : 1;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BOOKINGS);

  logic [TIME_BITS-1:0] mem_start [MAX_BOOKINGS];
  logic [TIME_BITS-1:0] mem_end   [MAX_BOOKINGS];

  logic [TIME_BITS-1:0] req_start;
  logic [TIME_BITS-1:0] req_end;
  logic [CW-1:0]        count;
  logic [CW-1:0]        idx;
  logic                 rd_vld;
  logic [TIME_BITS-1:0] rd_start;
  logic [TIME_BITS-1:0] rd_end;
  logic                 hit;
  logic                 issue;
  logic [ibe_pkg::STATUS_W-1:0] status;
  logic                 booked;

  assign issue         = cmd.scan && (idx != count);
  assign sts.scan_done = (idx == count) && !rd_vld;
  assign sts.out_free  = !m_tvalid || m_tready;

  always_comb begin
    priority if (req_start >= req_end) begin
      status = ibe_pkg::ST_INVALID;
    end else if (hit) begin
      status = ibe_pkg::ST_OVERLAP;
    end else if (count == MAX_CNT) begin
      status = ibe_pkg::ST_FULL;
    end else begin
      status = ibe_pkg::ST_BOOKED;
    end
  end

  assign booked = (status == ibe_pkg::ST_BOOKED);

  always_ff @(posedge clk) begin
    rd_start <= mem_start[idx[AW-1:0]];
    rd_end   <= mem_end[idx[AW-1:0]];
    if (cmd.finish && booked) begin
      mem_start[count[AW-1:0]] <= req_start;
      mem_end[count[AW-1:0]]   <= req_end;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_start <= in_start;
      req_end   <= in_end;
    end
    if (cmd.load) begin
      hit <= 1'b0;
    end else if (rd_vld && (req_start < rd_end) && (rd_start < req_end)) begin
      hit <= 1'b1;
    end
    if (cmd.finish) begin
      m_tdata <= {(ibe_pkg::OUT_W - ibe_pkg::STATUS_W - 1)'(0), status, booked};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      idx      <= '0;
      rd_vld   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      rd_vld <= issue;
      if (cmd.load) begin
        idx <= '0;
      end else if (issue) begin
        idx <= idx + 1'b1;
      end
      if (cmd.finish && booked) begin
        count <= count + 1'b1;
      end
      if (cmd.finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/interval_booking_engine_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_booking_engine_core
// Books half-open intervals [start, end) that overlap no booking held so far.
//
// Input channel s_*: one request per transfer, start_time and end_time.
// Output channel m_*: one result per request, accepted flag and status
// (booked, overlap conflict, table full, empty or reversed interval).
// A request is checked against every stored booking, one entry per cycle,
// through the single read port of the booking table; a booked request is
// then written to the next free entry.
// A new request is taken only once the result of the previous one has been
// loaded into the output register; s_tready is high only while idle.
// The result sits in an output register: while the receiver stalls, the
// next request is taken and scanned, and waits only for the register to
// free up before its result is loaded.
// Reset empties the booking table (count to zero) and drops any pending
// result; no clearing pass is needed.
// ----------------------------------------------------------------------------
module interval_booking_engine_core #(
  parameter int TIME_BITS    = ibe_pkg::TIME_BITS_DEF,
  parameter int MAX_BOOKINGS = ibe_pkg::MAX_BOOKINGS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // start_time [TIME_BITS-1:0], end_time [2*TIME_BITS-1:TIME_BITS], zero pad
  input  logic [((2*TIME_BITS+7)/8)*8-1:0]   s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // accepted [0], status [2:1], zero pad [7:3]
  output logic [ibe_pkg::OUT_W-1:0]          m_tdata
);

  ibe_pkg::ctl_cmd_t cmd;
  ibe_pkg::dp_sts_t  sts;

  ibe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ibe_datapath #(
    .TIME_BITS    (TIME_BITS),
    .MAX_BOOKINGS (MAX_BOOKINGS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_start (s_tdata[TIME_BITS-1:0]),
    .in_end   (s_tdata[2*TIME_BITS-1:TIME_BITS]),
    .cmd      (cmd),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for interval_booking_engine_core.
//
// Requests are half-open intervals sent over the s_* stream; every transfer
// is run through an in-bench booking table that predicts the accepted flag
// and status of its result. Results on the m_* stream are compared in order.
// A short directed table covers empty, reversed and extreme intervals,
// touching and overlapping neighbors; random traffic then fills the table
// and keeps probing it for overlaps and full-table rejections. Sender gaps
// and receiver stalls change by phase, with long output back-pressure and
// drained pauses.
// ----------------------------------------------------------------------------
module tb;

  localparam int TB_TIME_BITS = ibe_pkg::TIME_BITS_DEF;
  localparam int TB_BOOKINGS  = ibe_pkg::MAX_BOOKINGS_DEF;
  localparam int DATA_W       = ((2 * TB_TIME_BITS + 7) / 8) * 8;

  localparam logic [31:0] SPAN_MAX = (32'd1 << TB_TIME_BITS) - 32'd1;

  localparam int RANDOM_ITEMS = 1528;
  localparam int PHASE_LEN    = RANDOM_ITEMS / 4;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 2 * (TB_BOOKINGS + 4);

  typedef logic [TB_TIME_BITS-1:0] stamp_t;

  typedef struct packed {
    logic                         accepted;
    logic [ibe_pkg::STATUS_W-1:0] status;
  } result_t;

  typedef struct {
    stamp_t                       open_at;
    stamp_t                       close_at;
    bit                           typed;
    logic [ibe_pkg::STATUS_W-1:0] status;
  } dir_row_t;

  localparam stamp_t SMAX = '1;
  localparam int DIR_ROWS = 22;

  dir_row_t dir_table [DIR_ROWS] = '{
    '{30'd0,        30'd0,        1'b1, ibe_pkg::ST_INVALID},
    '{SMAX,         SMAX,         1'b1, ibe_pkg::ST_INVALID},
    '{SMAX,         30'd0,        1'b1, ibe_pkg::ST_INVALID},
    '{30'd5,        30'd4,        1'b1, ibe_pkg::ST_INVALID},
    '{30'd0,        30'd1,        1'b1, ibe_pkg::ST_BOOKED},
    '{SMAX - 30'd1, SMAX,         1'b1, ibe_pkg::ST_BOOKED},
    '{30'd0,        30'd1,        1'b1, ibe_pkg::ST_OVERLAP},
    '{30'd0,        SMAX,         1'b1, ibe_pkg::ST_OVERLAP},
    '{30'd1,        30'd2,        1'b0, ibe_pkg::ST_BOOKED},
    '{SMAX - 30'd2, SMAX - 30'd1, 1'b0, ibe_pkg::ST_BOOKED},
    '{30'd1,        30'd3,        1'b0, ibe_pkg::ST_BOOKED},
    '{30'd100,      30'd200,      1'b0, ibe_pkg::ST_BOOKED},
    '{30'd150,      30'd160,      1'b0, ibe_pkg::ST_BOOKED},
    '{30'd50,       30'd300,      1'b0, ibe_pkg::ST_BOOKED},
    '{30'd199,      30'd250,      1'b0, ibe_pkg::ST_BOOKED},
    '{30'd50,       30'd101,      1'b0, ibe_pkg::ST_BOOKED},
    '{30'd200,      30'd300,      1'b0, ibe_pkg::ST_BOOKED},
    '{30'd20,       30'd100,      1'b0, ibe_pkg::ST_BOOKED},
    '{30'h2AAAAAAA, 30'h2AAAAAAB, 1'b0, ibe_pkg::ST_BOOKED},
    '{30'h15555555, 30'h15555556, 1'b0, ibe_pkg::ST_BOOKED},
    '{30'd2,        SMAX - 30'd2, 1'b0, ibe_pkg::ST_BOOKED},
    '{30'd300,      30'd300,      1'b1, ibe_pkg::ST_INVALID}
  };

  logic                      clk;
  logic                      rst;
  logic                      s_tvalid;
  logic                      s_tready;
  logic [DATA_W-1:0]         s_tdata;
  logic                      m_tvalid;
  logic                      m_tready;
  logic [ibe_pkg::OUT_W-1:0] m_tdata;

  stamp_t      held_start [TB_BOOKINGS];
  stamp_t      held_end   [TB_BOOKINGS];
  int unsigned held_count = 0;

  result_t expected_results [$];
  int      mismatch_count     = 0;
  int      sender_idle_pct    = 0;
  int      receiver_stall_pct = 0;
  int      rx_hold_req        = 0;

  interval_booking_engine_core #(
    .TIME_BITS    (TB_TIME_BITS),
    .MAX_BOOKINGS (TB_BOOKINGS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic result_t book_interval(input stamp_t st, input stamp_t en);
    result_t r;
    logic    hit;
    hit = 1'b0;
    if (st >= en) begin
      r.status = ibe_pkg::ST_INVALID;
    end else begin
      for (int k = 0; k < held_count; k++)
        if (st < held_end[k] && held_start[k] < en) hit = 1'b1;
      if (hit) begin
        r.status = ibe_pkg::ST_OVERLAP;
      end else if (held_count >= TB_BOOKINGS) begin
        r.status = ibe_pkg::ST_FULL;
      end else begin
        held_start[held_count] = st;
        held_end[held_count]   = en;
        held_count++;
        r.status = ibe_pkg::ST_BOOKED;
      end
    end
    r.accepted = (r.status == ibe_pkg::ST_BOOKED);
    return r;
  endfunction

  task automatic pick_request(output stamp_t st, output stamp_t en);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] len;
    int unsigned k;
    int unsigned roll;
    roll = $urandom_range(99);
    len  = $urandom_range(32'd1 << $urandom_range(12), 1);
    k    = (held_count > 0) ? $urandom_range(held_count - 1) : 0;
    if (roll < 15 || held_count == 0) begin
      a = $urandom_range(SPAN_MAX);
      b = a + len;
    end else if (roll < 35) begin
      if ($urandom_range(1)) begin
        a = held_end[k];
        b = a + len;
      end else begin
        b = held_start[k];
        a = (b > len) ? b - len : 32'd0;
      end
    end else if (roll < 60) begin
      a = held_start[k] + $urandom_range(held_end[k] - held_start[k] - 1);
      b = a + len;
    end else if (roll < 70) begin
      if ($urandom_range(1)) begin
        a = held_end[k] - 1;
        b = a + len;
      end else begin
        b = held_start[k] + 1;
        a = (b > len) ? b - len : 32'd0;
      end
    end else if (roll < 82) begin
      b = $urandom_range(SPAN_MAX);
      a = b + $urandom_range(SPAN_MAX - b);
    end else begin
      a = $urandom() & SPAN_MAX;
      b = $urandom() & SPAN_MAX;
    end
    if (b > SPAN_MAX) b = SPAN_MAX;
    st = a[TB_TIME_BITS-1:0];
    en = b[TB_TIME_BITS-1:0];
  endtask

  task automatic offer_request(input stamp_t st, input stamp_t en, input bit typed,
                               input logic [ibe_pkg::STATUS_W-1:0] typed_status);
    result_t           predicted;
    logic [DATA_W-1:0] word;
    word = '0;
    word[TB_TIME_BITS-1:0]              = st;
    word[2*TB_TIME_BITS-1:TB_TIME_BITS] = en;
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
    predicted = book_interval(st, en);
    if (typed) begin
      predicted.status   = typed_status;
      predicted.accepted = (typed_status == ibe_pkg::ST_BOOKED);
    end
    expected_results.push_back(predicted);
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  initial begin : result_monitor
    result_t want;
    int      hold_left;
    hold_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no request pending: tdata %h", m_tdata);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (m_tdata[0] !== want.accepted) begin
            $error("accepted: expected %0d, actual %0d", want.accepted, m_tdata[0]);
            mismatch_count++;
          end
          if (m_tdata[2:1] !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, m_tdata[2:1]);
            mismatch_count++;
          end
        end
      end
      if (rx_hold_req != 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !(receiver_stall_pct != 0 && $urandom_range(99) < receiver_stall_pct);
      end
    end
  end

  initial begin : stimulus
    stamp_t st;
    stamp_t en;
    int     phase;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_table[i])
      offer_request(dir_table[i].open_at, dir_table[i].close_at,
                    dir_table[i].typed, dir_table[i].status);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % PHASE_LEN == 0) begin
        wait_for_results();
        phase = i / PHASE_LEN;
        case (phase)
          0: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
          end
          1: begin
            sender_idle_pct    = 88;
            receiver_stall_pct = 0;
          end
          2: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 88;
          end
          default: begin
            sender_idle_pct    = 28;
            receiver_stall_pct = 28;
          end
        endcase
        // hold the output while requests keep coming
        if (phase == 0 || phase == 3) rx_hold_req = HOLD_CYCLES;
      end
      pick_request(st, en);
      offer_request(st, en, 1'b0, ibe_pkg::ST_BOOKED);
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/ibe_pkg.sv
rtl/ibe_ctrl.sv
rtl/ibe_datapath.sv
rtl/interval_booking_engine_core.sv
verif/tb.sv
